[src/bffa_pkg.sv]
// Shared types and constants for the bitmap first-free allocator.
// Holds field widths, status and opcode codes and register indexes.
// No dependencies.
package bffa_pkg;

    localparam int NUM_W    = 14;
    localparam int ST_W     = 2;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    // Fixed-point shift for the reciprocal that splits a bit index into word and bit.
    localparam int RECIP_K  = NUM_W + 7;

    typedef logic [NUM_W-1:0] t_num;
    typedef logic [ST_W-1:0]  t_status;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

    localparam logic OP_ALLOC  = 1'b0;
    localparam logic OP_FREE   = 1'b1;
    localparam logic MAP_INODE = 1'b0;
    localparam logic MAP_BLOCK = 1'b1;

    localparam logic REG_IDX_INODE = 1'b0;
    localparam logic REG_IDX_BLOCK = 1'b1;

    localparam t_num CNT_RESET = 14'd8192;
    localparam t_num USED_MAX  = 14'h3FFF;

    // Map sizes in use, from the register block to the sequencer
    typedef struct packed {
        t_num inode_size;
        t_num block_size;
    } t_sizes;

    // Result of checking one bitmap word
    typedef struct packed {
        logic hit;
        logic last;
    } t_scan;

endpackage

[src/bffa_if.sv]
// Request and response channel interfaces of the bitmap first-free allocator.
// Depends on bffa_pkg.
interface bffa_req_if;
    import bffa_pkg::*;
    logic valid;
    logic ready;
    logic opcode;
    logic map_select;
    t_num entry_number;

    modport source (output valid, output opcode, output map_select, output entry_number,
                    input ready);
    modport sink   (input valid, input opcode, input map_select, input entry_number,
                    output ready);
endinterface

interface bffa_rsp_if;
    import bffa_pkg::*;
    logic    valid;
    logic    ready;
    t_num    allocated_number;
    t_status status;
    t_num    free_count;

    modport source (output valid, output allocated_number, output status, output free_count,
                    input ready);
    modport sink   (input valid, input allocated_number, input status, input free_count,
                    output ready);
endinterface

[src/bffa_map_ram.sv]
// Bitmap word store: one write port and one registered read port.
// No dependencies; contents are undefined until written.
module bffa_map_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/bffa_scan.sv]
// Word check unit: finds the lowest clear bit of one bitmap word and tests it
// against the map size in use. Depends on bffa_pkg.
module bffa_scan #(
    parameter int WORD_BITS = 32,
    localparam int PW       = $clog2(WORD_BITS),
    localparam int BW       = bffa_pkg::NUM_W + 1
) (
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [BW-1:0]        i_base,
    input  bffa_pkg::t_num       i_size,
    output logic [PW-1:0]        o_pos,
    output logic [BW-1:0]        o_cand,
    output bffa_pkg::t_scan      o_res
);
    import bffa_pkg::*;

    logic [WORD_BITS-1:0] w_free;
    logic                 w_any;
    logic [PW-1:0]        w_pos;
    logic [BW-1:0]        w_next;

    assign w_free = ~i_word;

    // Priority pick: lowest clear bit wins
    always_comb begin
        w_any = 1'b0;
        w_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w_free[i]) begin
                w_any = 1'b1;
                w_pos = PW'(i);
            end
        end
    end

    assign o_cand    = i_base + BW'(w_pos);
    assign w_next    = i_base + BW'(WORD_BITS);
    assign o_pos     = w_pos;
    assign o_res.hit  = w_any && (o_cand < {1'b0, i_size});
    assign o_res.last = (w_next >= {1'b0, i_size});

endmodule

[src/bffa_regs.sv]
// APB-style configuration registers: inode and block counts.
// Produces the map sizes in use, limited to the map capacity. Depends on bffa_pkg.
module bffa_regs #(
    parameter int MAP_BITS = 8192
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bffa_pkg::APB_AW-1:0] paddr,
    input  logic [bffa_pkg::APB_DW-1:0] pwdata,
    output logic [bffa_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output bffa_pkg::t_sizes            o_sizes
);
    import bffa_pkg::*;

    t_num r_inode_count;
    t_num r_block_count;
    logic w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inode_count <= CNT_RESET;
            r_block_count <= CNT_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                REG_IDX_INODE: r_inode_count <= pwdata[NUM_W-1:0];
                REG_IDX_BLOCK: r_block_count <= pwdata[NUM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_IDX_INODE: prdata = APB_DW'(r_inode_count);
            REG_IDX_BLOCK: prdata = APB_DW'(r_block_count);
            default:       prdata = '0;
        endcase
    end

    // Clamp to the capacity of the map
    assign o_sizes.inode_size = (32'(r_inode_count) > MAP_BITS) ? NUM_W'(MAP_BITS)
                                                                 : r_inode_count;
    assign o_sizes.block_size = (32'(r_block_count) > MAP_BITS) ? NUM_W'(MAP_BITS)
                                                                 : r_block_count;

endmodule

[src/bitmap_first_free_allocator.sv]
// Top level of the bitmap first-free allocator: sequencer, used counts and map store.
// Depends on bffa_pkg, bffa_if, bffa_regs, bffa_scan and bffa_map_ram.
//
// Usage:
//   i_req carries one transfer per request: opcode (allocate or free), map_select
//   (inode or block map) and entry_number (number to free). o_rsp returns one
//   transfer per request: allocated_number, status and free_count.
//   The APB-style port sets the inode and block counts; write it only while idle.
// Operation:
//   One request at a time; i_req.ready is high only while idle.
//   Allocate: the word check unit reads one bitmap word per cycle, up to the
//   first clear bit or up to the end of the map size in use; an empty map (count
//   zero) answers with a full status and no scan.
//   Free: a reciprocal multiply splits the number into word and bit, then a
//   read-modify-write clears the bit.
// Reset:
//   Counts return to 8192 and used counts to zero. A clearing pass then writes
//   every word of both maps to zero, during which no request is taken.
// Stall:
//   A result holds on o_rsp until taken; no new request is taken meanwhile.
module bitmap_first_free_allocator #(
    parameter int MAP_BITS  = 8192,
    parameter int WORD_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bffa_req_if.sink                    i_req,
    bffa_rsp_if.source                  o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bffa_pkg::APB_AW-1:0] paddr,
    input  logic [bffa_pkg::APB_DW-1:0] pwdata,
    output logic [bffa_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import bffa_pkg::*;

    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int RAM_AW    = AW + 1;
    localparam int RAM_DEPTH = 2 ** RAM_AW;
    localparam int PW        = $clog2(WORD_BITS);
    localparam int BW        = NUM_W + 1;
    // Exact floor division by WORD_BITS for any 14-bit index
    localparam int RECIP     = (2 ** RECIP_K + WORD_BITS - 1) / WORD_BITS;
    localparam int MW        = $clog2(RECIP + 1);
    localparam int PRW       = NUM_W + MW;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_SPLIT  = 3'd4;
    localparam logic [2:0] S_FREE   = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    logic [2:0]        r_state;
    logic [RAM_AW-1:0] r_clr_addr;
    logic              r_op;
    logic              r_sel;
    t_num              r_idx;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_word;
    logic [BW-1:0]     r_base;
    logic              r_pend;
    logic [AW-1:0]     r_q;
    logic [PW-1:0]     r_pos;
    t_num              r_out_num;
    t_status           r_status;
    t_num              r_inodes_used;
    t_num              r_blocks_used;

    t_sizes                w_sizes;
    t_num                  w_size;
    t_num                  w_req_size;
    t_num                  w_used;
    logic                  w_req_ok;
    logic                  w_accept;
    logic                  w_we;
    logic [RAM_AW-1:0]     w_waddr;
    logic [WORD_BITS-1:0]  w_wdata;
    logic [RAM_AW-1:0]     w_raddr;
    logic [WORD_BITS-1:0]  w_rdata;
    logic [PW-1:0]         w_scan_pos;
    logic [BW-1:0]         w_cand;
    t_scan                 w_scan;
    logic [PRW-1:0]        w_prod;
    t_num                  w_qw;

    bffa_regs #(
        .MAP_BITS (MAP_BITS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_sizes (w_sizes)
    );

    bffa_map_ram #(
        .DEPTH (RAM_DEPTH),
        .WIDTH (WORD_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bffa_scan #(
        .WORD_BITS (WORD_BITS)
    ) u_scan (
        .i_word (w_rdata),
        .i_base (r_base),
        .i_size (w_size),
        .o_pos  (w_scan_pos),
        .o_cand (w_cand),
        .o_res  (w_scan)
    );

    // Size and used count of the map being worked on
    assign w_size     = (r_sel == MAP_BLOCK) ? w_sizes.block_size : w_sizes.inode_size;
    assign w_used     = (r_sel == MAP_BLOCK) ? r_blocks_used : r_inodes_used;
    assign w_req_size = (i_req.map_select == MAP_BLOCK) ? w_sizes.block_size
                                                        : w_sizes.inode_size;

    // Range check of a free: inode numbers run from one, block numbers from zero
    assign w_req_ok = (i_req.map_select == MAP_BLOCK)
                    ? (i_req.entry_number < w_req_size)
                    : ((i_req.entry_number != '0) && (i_req.entry_number <= w_req_size));

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // Word and bit of a freed index: multiply by the reciprocal, then take the remainder
    assign w_prod = PRW'(r_idx) * PRW'(RECIP);
    assign w_qw   = NUM_W'(r_q * WORD_BITS);

    // Read the scan pointer while scanning, else the word of the entry to free
    assign w_raddr = (r_state == S_SCAN) ? {r_sel, r_addr} : {r_sel, r_q};

    always_comb begin
        w_we    = 1'b0;
        w_waddr = {r_sel, r_q};
        w_wdata = w_rdata & ~(WORD_BITS'(1) << r_pos);
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
            end
            S_SCAN: begin
                w_we    = r_pend && w_scan.hit;
                w_waddr = {r_sel, r_word};
                w_wdata = w_rdata | (WORD_BITS'(1) << w_scan_pos);
            end
            S_FREE: begin
                w_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_pend        <= 1'b0;
            r_inodes_used <= '0;
            r_blocks_used <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    // Sweep both maps to zero, one word a cycle
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_op      <= i_req.opcode;
                        r_sel     <= i_req.map_select;
                        r_out_num <= '0;
                        r_addr    <= '0;
                        r_word    <= '0;
                        r_base    <= '0;
                        r_pend    <= 1'b0;
                        r_idx     <= (i_req.map_select == MAP_BLOCK)
                                   ? i_req.entry_number : i_req.entry_number - 1'b1;
                        if (i_req.opcode == OP_ALLOC) begin
                            if (w_req_size == '0) begin
                                r_status <= ST_FULL;
                                r_state  <= S_RESULT;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else if (w_req_ok) begin
                            r_state <= S_DIV;
                        end else begin
                            r_status <= ST_RANGE;
                            r_state  <= S_RESULT;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue the next word while the word read last cycle is checked
                    r_addr <= r_addr + 1'b1;
                    r_pend <= 1'b1;
                    if (r_pend) begin
                        if (w_scan.hit) begin
                            r_out_num <= (r_sel == MAP_BLOCK) ? w_cand[NUM_W-1:0]
                                                              : NUM_W'(w_cand + 1'b1);
                            r_status  <= ST_OK;
                            r_state   <= S_RESULT;
                            if (r_sel == MAP_BLOCK) begin
                                if (r_blocks_used != USED_MAX) begin
                                    r_blocks_used <= r_blocks_used + 1'b1;
                                end
                            end else if (r_inodes_used != USED_MAX) begin
                                r_inodes_used <= r_inodes_used + 1'b1;
                            end
                        end else if (w_scan.last) begin
                            r_status <= ST_FULL;
                            r_state  <= S_RESULT;
                        end else begin
                            r_word <= r_word + 1'b1;
                            r_base <= r_base + BW'(WORD_BITS);
                        end
                    end
                end
                S_DIV: begin
                    r_q     <= AW'(w_prod >> RECIP_K);
                    r_state <= S_SPLIT;
                end
                S_SPLIT: begin
                    r_pos   <= PW'(r_idx - w_qw);
                    r_state <= S_FREE;
                end
                S_FREE: begin
                    // Clear the bit; the used count drops even if it was clear
                    r_status <= ST_OK;
                    r_state  <= S_RESULT;
                    if (r_sel == MAP_BLOCK) begin
                        if (r_blocks_used != '0) begin
                            r_blocks_used <= r_blocks_used - 1'b1;
                        end
                    end else if (r_inodes_used != '0) begin
                        r_inodes_used <= r_inodes_used - 1'b1;
                    end
                end
                S_RESULT: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Hold the result until the receiver takes it
    assign o_rsp.valid            = (r_state == S_RESULT);
    assign o_rsp.allocated_number = r_out_num;
    assign o_rsp.status           = r_status;
    assign o_rsp.free_count       = (w_size > w_used) ? w_size - w_used : '0;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !i_req.ready)
        else $error("request taken while a result is pending");

    a_inode_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && r_op == OP_ALLOC && r_sel == MAP_INODE && r_status == ST_OK)
        |-> (r_out_num != '0))
        else $error("inode zero handed out");

    a_free_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.free_count <= w_size))
        else $error("free count above map size");

    a_range_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.opcode == OP_FREE && !w_req_ok)
        |=> (r_state == S_RESULT && r_status == ST_RANGE))
        else $error("out of range free not rejected at once");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the bitmap first-free allocator.
// Depends on bffa_pkg, bffa_if and bitmap_first_free_allocator from the RTL.
module tb_top;
    import bffa_pkg::*;

    localparam int MAP_BITS    = 8192;
    localparam int WORD_BITS   = 32;
    // Longest allocate scan plus margin: every word of the map, then the pipeline.
    localparam int SCAN_CYCLES = MAP_BITS / WORD_BITS + 8;
    localparam int QUIET_LIMIT = 4000;

    // One request transfer and one response transfer
    typedef struct packed {
        logic opcode;
        logic map_select;
        t_num entry_number;
    } t_req;

    typedef struct packed {
        t_num    allocated_number;
        t_status status;
        t_num    free_count;
    } t_rsp;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    bffa_req_if req_ch ();
    bffa_rsp_if rsp_ch ();

    bitmap_first_free_allocator #(
        .MAP_BITS  (MAP_BITS),
        .WORD_BITS (WORD_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the allocator: both maps, their used counts and the
    // two count registers. Indexed by map_select for the maps, by register
    // index for the counts.
    bit [MAP_BITS-1:0] shadow_map [2];
    int unsigned       shadow_used [2];
    t_num              shadow_count [2];

    t_req request_q [$];        // requests waiting to be offered
    t_rsp expected_rsp_q [$];   // responses owed by the allocator, oldest first

    t_req next_req;
    t_rsp want;
    int   err_count   = 0;
    int   quiet_cycles = 0;
    int   gap_pct      = 14;    // chance in a hundred that a side idles this cycle
    bit   hold_send    = 1'b0;  // stop offering new requests while set

    // Size of a map in use: its count register, clamped to the map size.
    function automatic int map_size(logic map_sel);
        t_num cnt;
        cnt = shadow_count[(map_sel == MAP_BLOCK) ? REG_IDX_BLOCK : REG_IDX_INODE];
        return (cnt > MAP_BITS) ? MAP_BITS : int'(cnt);
    endfunction

    // Apply one accepted request to the shadow state and return the response
    // the allocator owes for it.
    function automatic t_rsp predict_allocation(t_req rq);
        t_rsp r;
        int   span;
        int   m;
        int   idx;
        logic found;
        logic in_range;
        m    = (rq.map_select == MAP_BLOCK) ? 1 : 0;
        span = map_size(rq.map_select);
        r    = '0;
        r.status = ST_OK;
        if (rq.opcode == OP_ALLOC) begin
            // Lowest clear bit below the size in use; none means the map is full.
            r.status = ST_FULL;
            found    = 1'b0;
            for (int i = 0; i < span && !found; i++) begin
                if (!shadow_map[m][i]) begin
                    shadow_map[m][i] = 1'b1;
                    if (shadow_used[m] < USED_MAX)
                        shadow_used[m]++;
                    r.allocated_number = (rq.map_select == MAP_BLOCK) ? t_num'(i) : t_num'(i + 1);
                    r.status = ST_OK;
                    found    = 1'b1;
                end
            end
        end else begin
            // Inode numbers run from 1, block numbers from 0.
            if (rq.map_select == MAP_BLOCK) begin
                in_range = (int'(rq.entry_number) < span);
                idx      = int'(rq.entry_number);
            end else begin
                in_range = (rq.entry_number >= 1) && (int'(rq.entry_number) <= span);
                idx      = int'(rq.entry_number) - 1;
            end
            // A free of a clear entry still counts back, saturating at zero.
            if (in_range) begin
                shadow_map[m][idx] = 1'b0;
                if (shadow_used[m] > 0)
                    shadow_used[m]--;
            end else begin
                r.status = ST_RANGE;
            end
        end
        r.free_count = (span > shadow_used[m]) ? t_num'(span - shadow_used[m]) : '0;
        return r;
    endfunction

    function automatic void push_req(logic op, logic map_sel, t_num num);
        t_req rq;
        rq.opcode       = op;
        rq.map_select   = map_sel;
        rq.entry_number = num;
        request_q.push_back(rq);
    endfunction

    // Queue random requests against the sizes now in force. Most frees name a
    // number in range, many of them low where allocations cluster; the rest
    // hit the range edges or are any 14-bit value.
    task automatic queue_random(input int n, input int alloc_pct);
        int   span;
        int   base;
        int   pick;
        int   low_span;
        logic op;
        logic map_sel;
        t_num num;
        repeat (n) begin
            op       = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_FREE;
            map_sel  = $urandom_range(1) ? MAP_BLOCK : MAP_INODE;
            span     = map_size(map_sel);
            base     = (map_sel == MAP_INODE) ? 1 : 0;
            low_span = (span < 96) ? span : 96;
            pick     = $urandom_range(99);
            if (op == OP_ALLOC || pick >= 90 || span == 0) begin
                num = t_num'($urandom_range(16383));
            end else if (pick < 45) begin
                num = t_num'(base + $urandom_range(low_span - 1));
            end else if (pick < 80) begin
                num = t_num'(base + $urandom_range(span - 1));
            end else begin
                case ($urandom_range(3))
                    0:       num = t_num'(base - 1);
                    1:       num = t_num'(base + span - 1);
                    2:       num = t_num'(base + span);
                    default: num = t_num'(base + span + 1);
                endcase
            end
            push_req(op, map_sel, num);
        end
    endtask

    // Wait until every request has gone and every response has come back.
    task automatic settle();
        do @(negedge i_clk);
        while (request_q.size() != 0 || req_ch.valid || expected_rsp_q.size() != 0);
    endtask

    // One APB write: setup cycle, then access cycle; the register takes the
    // value at the edge where the access completes.
    task automatic cfg_write(input logic idx, input t_num value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_count[idx] = value;
    endtask

    task automatic set_counts(input t_num inode_cnt, input t_num block_cnt);
        settle();
        cfg_write(REG_IDX_INODE, inode_cnt);
        cfg_write(REG_IDX_BLOCK, block_cnt);
    endtask

    // Request driver: predict on each accepted transfer, then offer the next
    // request unless idling, held off or out of work. Keep valid high until
    // the offered request has been taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                next_req.opcode       = req_ch.opcode;
                next_req.map_select   = req_ch.map_select;
                next_req.entry_number = req_ch.entry_number;
                expected_rsp_q.push_back(predict_allocation(next_req));
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (request_q.size() != 0 && !hold_send && $urandom_range(99) >= gap_pct) begin
                    next_req = request_q.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.opcode       <= next_req.opcode;
                    req_ch.map_select   <= next_req.map_select;
                    req_ch.entry_number <= next_req.entry_number;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: compare each transfer with the oldest expectation,
    // field by field, and stall the allocator at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $display("%0t: response with none owed: number=%0d status=%0d free=%0d",
                             $time, rsp_ch.allocated_number, rsp_ch.status, rsp_ch.free_count);
                    err_count++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (rsp_ch.allocated_number !== want.allocated_number) begin
                        $display("%0t: allocated_number expected %0d got %0d",
                                 $time, want.allocated_number, rsp_ch.allocated_number);
                        err_count++;
                    end
                    if (rsp_ch.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, rsp_ch.status);
                        err_count++;
                    end
                    if (rsp_ch.free_count !== want.free_count) begin
                        $display("%0t: free_count expected %0d got %0d",
                                 $time, want.free_count, rsp_ch.free_count);
                        err_count++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= gap_pct);
        end
    end

    // Watchdog: count cycles with no transfer on either channel. The clearing
    // pass after reset and the longest allocate scan sit well inside the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // Known values on every input before the first edge
        req_ch.valid        = 1'b0;
        req_ch.opcode       = OP_ALLOC;
        req_ch.map_select   = MAP_INODE;
        req_ch.entry_number = '0;
        rsp_ch.ready        = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        // Shadow state after reset: both counts at their reset value, maps empty
        shadow_map[0]   = '0;
        shadow_map[1]   = '0;
        shadow_used[0]  = 0;
        shadow_used[1]  = 0;
        shadow_count[REG_IDX_INODE] = CNT_RESET;
        shadow_count[REG_IDX_BLOCK] = CNT_RESET;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset counts: first allocations, then range
        // edges on both maps, frees of clear entries with the used count
        // saturating at zero, and allocations with junk in entry_number.
        push_req(OP_ALLOC, MAP_INODE, 14'd0);
        push_req(OP_ALLOC, MAP_BLOCK, 14'd0);
        push_req(OP_FREE,  MAP_INODE, 14'd0);
        push_req(OP_FREE,  MAP_INODE, 14'd8193);
        push_req(OP_FREE,  MAP_INODE, 14'h3FFF);
        push_req(OP_FREE,  MAP_INODE, 14'd8192);
        push_req(OP_FREE,  MAP_INODE, 14'd1);
        push_req(OP_FREE,  MAP_BLOCK, 14'd8192);
        push_req(OP_FREE,  MAP_BLOCK, 14'd8191);
        push_req(OP_FREE,  MAP_BLOCK, 14'd0);
        push_req(OP_ALLOC, MAP_INODE, 14'h3FFF);
        push_req(OP_ALLOC, MAP_BLOCK, 14'h2AAA);

        // Counts of zero: no entry exists, allocate reports full, any free is out of range
        set_counts(14'd0, 14'd0);
        push_req(OP_ALLOC, MAP_INODE, 14'h1555);
        push_req(OP_ALLOC, MAP_BLOCK, 14'd0);
        push_req(OP_FREE,  MAP_INODE, 14'd1);
        push_req(OP_FREE,  MAP_BLOCK, 14'd0);

        // Inode count above the map size clamps to it; the one-entry block map starts full, then is freed and refilled
        set_counts(14'h3FFF, 14'd1);
        push_req(OP_ALLOC, MAP_BLOCK, 14'd0);
        push_req(OP_FREE,  MAP_BLOCK, 14'd1);
        push_req(OP_FREE,  MAP_BLOCK, 14'd0);
        push_req(OP_ALLOC, MAP_BLOCK, 14'd0);
        push_req(OP_FREE,  MAP_INODE, 14'd8192);
        push_req(OP_ALLOC, MAP_INODE, 14'd0);
        push_req(OP_FREE,  MAP_INODE, 14'd8193);

        // Random phases. Small maps fill up and drain, so full and range
        // answers come often; large maps are kept short.
        set_counts(14'd40, 14'd33);
        queue_random(250, 65);

        // Full-size maps with no idling on either side
        set_counts(CNT_RESET, CNT_RESET);
        gap_pct = 0;
        queue_random(250, 60);
        settle();
        gap_pct = 14;

        set_counts(14'd1, 14'd2);
        queue_random(150, 55);

        set_counts(14'h3FFF, 14'd8191);
        queue_random(200, 55);

        // Hold the sender partway through until every owed response has arrived
        set_counts(14'd7, 14'd64);
        queue_random(250, 50);
        while (request_q.size() > 125) @(negedge i_clk);
        hold_send = 1'b1;
        do @(negedge i_clk);
        while (req_ch.valid || expected_rsp_q.size() != 0);
        repeat (3) @(negedge i_clk);
        hold_send = 1'b0;

        set_counts(14'd0, 14'd5);
        queue_random(100, 50);

        set_counts(14'd130, 14'd100);
        queue_random(250, 70);

        // Drain, then allow for a stray late response before deciding
        settle();
        repeat (SCAN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (expected_rsp_q.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, expected_rsp_q.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
src/bffa_pkg.sv
src/bffa_if.sv
src/bffa_map_ram.sv
src/bffa_scan.sv
src/bffa_regs.sv
src/bitmap_first_free_allocator.sv
sim/tb_top.sv
